// ----- hw/rtl/mktd_pkg.sv -----
// Shared types, codes and reset values for the Morse key timing decoder.
`default_nettype none
package mktd_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int SYM_W  = 15;
  localparam int CNT_W  = 4;
  localparam int PH_W   = 3;
  localparam int IDX_W  = 3;

  localparam int DEFAULT_SYMBOL_CAPACITY = 15;

  // phase codes
  localparam logic [PH_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PH_W-1:0] PH_PRESSED  = 3'd1;
  localparam logic [PH_W-1:0] PH_GAP      = 3'd2;
  localparam logic [PH_W-1:0] PH_COMPLETE = 3'd3;
  localparam logic [PH_W-1:0] PH_STUCK    = 3'd4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_TOUCH_MIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_DOT_MAX     = 3'd1;
  localparam logic [IDX_W-1:0] REG_DASH_MIN    = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAP_TIMEOUT = 3'd3;
  localparam logic [IDX_W-1:0] REG_STUCK_LIMIT = 3'd4;

  // configuration reset values
  localparam logic [CFG_W-1:0] RST_TOUCH_MIN   = 16'd30;
  localparam logic [CFG_W-1:0] RST_DOT_MAX     = 16'd200;
  localparam logic [CFG_W-1:0] RST_DASH_MIN    = 16'd300;
  localparam logic [CFG_W-1:0] RST_GAP_TIMEOUT = 16'd1000;
  localparam logic [CFG_W-1:0] RST_STUCK_LIMIT = 16'd5000;

  // input item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic              func;
    logic              key_down;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [PH_W-1:0]  phase;
    logic [CNT_W-1:0] symbol_count;
    logic [SYM_W-1:0] symbol_bits;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] touch_min_ms;
    logic [CFG_W-1:0] dot_max_ms;
    logic [CFG_W-1:0] dash_min_ms;
    logic [CFG_W-1:0] gap_timeout_ms;
    logic [CFG_W-1:0] stuck_limit_ms;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mktd_cfg_regs.sv -----
// Configuration register file for the Morse key timing decoder.
`default_nettype none
module mktd_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [mktd_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [mktd_pkg::CFG_W-1:0]  cfg_data,
  output mktd_pkg::cfg_t                   cfg
);
  import mktd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.touch_min_ms   <= RST_TOUCH_MIN;
      cfg.dot_max_ms     <= RST_DOT_MAX;
      cfg.dash_min_ms    <= RST_DASH_MIN;
      cfg.gap_timeout_ms <= RST_GAP_TIMEOUT;
      cfg.stuck_limit_ms <= RST_STUCK_LIMIT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_TOUCH_MIN:   cfg.touch_min_ms   <= cfg_data;
        REG_DOT_MAX:     cfg.dot_max_ms     <= cfg_data;
        REG_DASH_MIN:    cfg.dash_min_ms    <= cfg_data;
        REG_GAP_TIMEOUT: cfg.gap_timeout_ms <= cfg_data;
        REG_STUCK_LIMIT: cfg.stuck_limit_ms <= cfg_data;
        default: ;  // writes beyond the list are ignored
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mktd_step.sv -----
// Decoder state and the single-pass next-state logic for one key item.
`default_nettype none
module mktd_step #(
  parameter int SYMBOL_CAPACITY = mktd_pkg::DEFAULT_SYMBOL_CAPACITY
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  mktd_pkg::in_item_t  item,
  input  mktd_pkg::cfg_t      cfg,
  output mktd_pkg::out_item_t result
);
  import mktd_pkg::*;

  localparam int CapInt = (SYMBOL_CAPACITY < SYM_W) ? SYMBOL_CAPACITY : SYM_W;
  localparam logic [CNT_W-1:0] StoreCap = CNT_W'(CapInt);

  logic [PH_W-1:0]   phase, phase_next;
  logic              last_level, last_level_next;
  logic [TIME_W-1:0] press_start, press_start_next;
  logic [TIME_W-1:0] release_time, release_time_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [SYM_W-1:0]  symbols, symbols_next;

  logic              rising, falling;
  logic [TIME_W-1:0] held, silence;
  logic              is_stuck, is_dash, is_dot, gap_done;

  assign rising   = item.key_down & ~last_level;
  assign falling  = ~item.key_down & last_level;
  assign held     = item.time_ms - press_start;
  assign silence  = item.time_ms - release_time;
  assign is_stuck = held > {{(TIME_W-CFG_W){1'b0}}, cfg.stuck_limit_ms};
  assign is_dash  = held >= {{(TIME_W-CFG_W){1'b0}}, cfg.dash_min_ms};
  assign is_dot   = (held >= {{(TIME_W-CFG_W){1'b0}}, cfg.touch_min_ms}) &&
                    (held <= {{(TIME_W-CFG_W){1'b0}}, cfg.dot_max_ms});
  assign gap_done = silence >= {{(TIME_W-CFG_W){1'b0}}, cfg.gap_timeout_ms};

  always_comb begin
    phase_next        = phase;
    last_level_next   = item.key_down;
    press_start_next  = press_start;
    release_time_next = release_time;
    count_next        = count;
    symbols_next      = symbols;

    if (item.func == FUNC_CLEAR) begin
      phase_next        = PH_IDLE;
      last_level_next   = 1'b0;
      press_start_next  = '0;
      release_time_next = '0;
      count_next        = '0;
      symbols_next      = '0;
    end else begin
      unique case (phase) inside
        PH_IDLE, PH_GAP: begin
          if (rising) begin
            press_start_next = item.time_ms;
            phase_next       = PH_PRESSED;
          end else if (phase == PH_GAP && count != '0 && gap_done) begin
            phase_next = PH_COMPLETE;
          end
        end
        PH_PRESSED: begin
          if (is_stuck) begin
            phase_next = PH_STUCK;
          end else if (falling) begin
            // append a symbol unless the store is full; dash wins on overlap
            if ((is_dash || is_dot) && count < StoreCap) begin
              symbols_next[count] = is_dash;
              count_next          = count + 1'b1;
            end
            release_time_next = item.time_ms;
            phase_next        = PH_GAP;
          end
        end
        PH_STUCK: begin
          if (falling) begin
            phase_next        = PH_IDLE;
            press_start_next  = '0;
            release_time_next = '0;
            count_next        = '0;
            symbols_next      = '0;
          end
        end
        default: ;  // complete: hold until a clear item
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      last_level   <= 1'b0;
      press_start  <= '0;
      release_time <= '0;
      count        <= '0;
      symbols      <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      last_level   <= last_level_next;
      press_start  <= press_start_next;
      release_time <= release_time_next;
      count        <= count_next;
      symbols      <= symbols_next;
    end
  end

  assign result.phase        = phase_next;
  assign result.symbol_count = count_next;
  assign result.symbol_bits  = symbols_next;

endmodule
`default_nettype wire

// ----- hw/rtl/morse_key_timing_decoder.sv -----
// Top level of the Morse key timing decoder: input register, step logic, result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | to block  | in_valid / in_stall  | in_item: func, key_down, time_ms
//   out     | from block| out_valid / out_stall| out_item: phase, symbol_count,
//           |           |                      |           symbol_bits
//   cfg     | to block  | cfg_wen              | cfg_index, cfg_data
//
// An item's result reaches out_item by way of the input register and the result
// register: the item sits in the input register while the step logic works on it,
// and the result register loads when the item fires.
// One item per cycle is sustained while out_stall stays low; the step unit's state
// loads as the item fires, so a new item can follow its predecessor directly.
// rst is synchronous: it empties both registers and returns state and
// configuration to their reset values.
// out_stall holds the result register; the input register still takes one
// more item while a result waits, after which in_stall rises.
`default_nettype none
module morse_key_timing_decoder #(
  parameter int SYMBOL_CAPACITY = mktd_pkg::DEFAULT_SYMBOL_CAPACITY
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  mktd_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output mktd_pkg::out_item_t             out_item,
  input  wire logic                       cfg_wen,
  input  wire logic [mktd_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [mktd_pkg::CFG_W-1:0] cfg_data
);
  import mktd_pkg::*;

  localparam int CapInt = (SYMBOL_CAPACITY < SYM_W) ? SYMBOL_CAPACITY : SYM_W;
  localparam logic [CNT_W-1:0] StoreCap = CNT_W'(CapInt);

  cfg_t      cfg;
  in_item_t  hold_item;
  logic      hold_valid;
  out_item_t result;
  logic      out_free;
  logic      fire;

  // result register can load when empty or draining this cycle
  assign out_free = ~out_valid | ~out_stall;
  // advance the held item through the step logic
  assign fire     = hold_valid & out_free;
  // stall upstream only when the input register is full and cannot drain
  assign in_stall = hold_valid & ~out_free;

  mktd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mktd_step #(
    .SYMBOL_CAPACITY (SYMBOL_CAPACITY)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  // input register: take a new item whenever the held one leaves or is absent
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (~in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (~in_stall && in_valid) begin
      hold_item <= in_item;
    end
  end

  // result register: load on fire, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.symbol_count <= StoreCap)
    else $error("symbol count beyond store capacity");

  a_bits_above_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.symbol_bits >> out_item.symbol_count) == '0)
    else $error("symbol bits set above symbol count");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (fire && hold_item.func == FUNC_CLEAR) |=>
      (out_item.phase == PH_IDLE && out_item.symbol_count == '0 &&
       out_item.symbol_bits == '0))
    else $error("clear item did not return decoder to idle");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_valid && out_valid))
    else $error("input stalled without a held item and a waiting result");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the Morse key timing decoder: timed key stimulus and a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import mktd_pkg::*;

  // Track the decoder state, predict one result per accepted item and
  // compare the results that come out in order.
  class decoder_scoreboard;
    cfg_t             cfg;
    int unsigned      capacity;
    logic [PH_W-1:0]  ph;
    logic             last_lvl;
    logic [TIME_W-1:0] t_press;
    logic [TIME_W-1:0] t_release;
    logic [CNT_W-1:0] cnt;
    logic [SYM_W-1:0] syms;
    out_item_t        expected_results[$];
    int               errors;
    int               checked;
    int               n_complete;
    int               n_stuck;
    int               n_full;

    function new(int unsigned cap);
      capacity = (cap < SYM_W) ? cap : SYM_W;
      cfg.touch_min_ms   = RST_TOUCH_MIN;
      cfg.dot_max_ms     = RST_DOT_MAX;
      cfg.dash_min_ms    = RST_DASH_MIN;
      cfg.gap_timeout_ms = RST_GAP_TIMEOUT;
      cfg.stuck_limit_ms = RST_STUCK_LIMIT;
      clear_state();
      errors = 0;
      checked = 0;
      n_complete = 0;
      n_stuck = 0;
      n_full = 0;
    endfunction

    function void clear_state();
      ph = PH_IDLE;
      last_lvl = 1'b0;
      t_press = '0;
      t_release = '0;
      cnt = '0;
      syms = '0;
    endfunction

    // Drop the symbol silently once the store is full.
    function void push_symbol(bit is_dash);
      if (cnt < capacity) begin
        if (is_dash) syms[cnt] = 1'b1;
        cnt = cnt + 1'b1;
      end
    endfunction

    function void note_key_item(in_item_t it);
      logic [TIME_W-1:0] held;
      logic              rising;
      logic              falling;
      out_item_t         res;
      if (it.func == FUNC_CLEAR) begin
        clear_state();
      end else begin
        rising  = it.key_down && !last_lvl;
        falling = !it.key_down && last_lvl;
        case (ph)
          PH_IDLE, PH_GAP: begin
            held = it.time_ms - t_release;
            if (rising) begin
              t_press = it.time_ms;
              ph = PH_PRESSED;
            end else if (ph == PH_GAP && cnt != 0 && held >= cfg.gap_timeout_ms) begin
              ph = PH_COMPLETE;
            end
          end
          PH_PRESSED: begin
            held = it.time_ms - t_press;
            if (held > cfg.stuck_limit_ms) begin
              ph = PH_STUCK;
            end else if (falling) begin
              if (held >= cfg.dash_min_ms) begin
                push_symbol(1'b1);
              end else if (held >= cfg.touch_min_ms && held <= cfg.dot_max_ms) begin
                push_symbol(1'b0);
              end
              t_release = it.time_ms;
              ph = PH_GAP;
            end
          end
          PH_STUCK: begin
            if (falling) clear_state();
          end
          default: ;
        endcase
        last_lvl = it.key_down;
      end
      if (ph == PH_COMPLETE) n_complete++;
      if (ph == PH_STUCK) n_stuck++;
      if (cnt == capacity) n_full++;
      res.phase = ph;
      res.symbol_count = cnt;
      res.symbol_bits = syms;
      expected_results.push_back(res);
    endfunction

    function void mismatch(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 30) $error("%s: expected %0d, actual %0d", field, want, got);
    endfunction

    function void check_decoder_result(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_results.size() == 0) begin
        errors++;
        $error("result with no item pending: phase %0d count %0d bits %h",
               got.phase, got.symbol_count, got.symbol_bits);
        return;
      end
      want = expected_results.pop_front();
      if (got.phase !== want.phase) mismatch("phase", want.phase, got.phase);
      if (got.symbol_count !== want.symbol_count)
        mismatch("symbol_count", want.symbol_count, got.symbol_count);
      if (got.symbol_bits !== want.symbol_bits)
        mismatch("symbol_bits", want.symbol_bits, got.symbol_bits);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_wen;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  decoder_scoreboard sb;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          holdoff_req = 0;
  int          holdoff_seen;
  int          holdoff_left;
  int          items_sent = 0;
  int          settings_used = 0;
  logic [31:0] now_ms = '0;

  morse_key_timing_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // that the block fills up and pushes back on its input.
  initial begin
    out_stall = 1'b0;
    holdoff_left = 0;
    holdoff_seen = 0;
    forever begin
      @(posedge clk);
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (holdoff_seen != holdoff_req) begin
        holdoff_seen = holdoff_req;
        holdoff_left = 299;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Check every result taken at an edge against the oldest prediction.
  always @(posedge clk) begin
    if (rst == 1'b0 && out_valid && !out_stall) sb.check_decoder_result(out_item);
  end

  // Offer one item, idling first at random; hold it until it is taken.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_key_item(it);
    items_sent++;
  endtask

  task automatic emit(input logic f, input logic lvl, input logic [31:0] t);
    in_item_t it;
    it.func = f;
    it.key_down = lvl;
    it.time_ms = t;
    send_item(it);
  endtask

  // Write all five registers back to back, then drop the write enable.
  task automatic set_config(input cfg_t c);
    cfg_wen <= 1'b1;
    cfg_index <= REG_TOUCH_MIN;
    cfg_data <= c.touch_min_ms;
    @(posedge clk);
    cfg_index <= REG_DOT_MAX;
    cfg_data <= c.dot_max_ms;
    @(posedge clk);
    cfg_index <= REG_DASH_MIN;
    cfg_data <= c.dash_min_ms;
    @(posedge clk);
    cfg_index <= REG_GAP_TIMEOUT;
    cfg_data <= c.gap_timeout_ms;
    @(posedge clk);
    cfg_index <= REG_STUCK_LIMIT;
    cfg_data <= c.stuck_limit_ms;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.cfg = c;
    settings_used++;
  endtask

  // Mostly sensible timing with windows that may overlap, sometimes anything at all.
  task automatic random_config();
    cfg_t c;
    if ($urandom_range(0, 3) == 0) begin
      c.touch_min_ms   = $urandom;
      c.dot_max_ms     = $urandom;
      c.dash_min_ms    = $urandom;
      c.gap_timeout_ms = $urandom;
      c.stuck_limit_ms = $urandom;
    end else begin
      c.touch_min_ms   = $urandom_range(0, 100);
      c.dot_max_ms     = c.touch_min_ms + $urandom_range(0, 300);
      c.dash_min_ms    = $urandom_range(c.dot_max_ms / 2, c.dot_max_ms + 400);
      c.gap_timeout_ms = $urandom_range(50, 3000);
      c.stuck_limit_ms = c.dash_min_ms + $urandom_range(0, 3000);
    end
    set_config(c);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  // Let everything drain so that registers can be written safely.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pick a hold time: dots and dashes mostly, thresholds, short taps and stuck keys.
  function automatic logic [31:0] pick_hold();
    int unsigned tmin;
    int unsigned dmax;
    int unsigned dmin;
    int unsigned stk;
    int unsigned span;
    logic [31:0] h;
    tmin = sb.cfg.touch_min_ms;
    dmax = sb.cfg.dot_max_ms;
    dmin = sb.cfg.dash_min_ms;
    stk  = sb.cfg.stuck_limit_ms;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: h = (tmin <= dmax) ? $urandom_range(tmin, dmax) : tmin;
      4, 5, 6: begin
        span = (stk > dmin) ? stk - dmin : 0;
        if (span > 2000) span = 2000;
        h = dmin + $urandom_range(0, span);
      end
      7: begin
        case ($urandom_range(0, 7))
          0: h = tmin - 1;
          1: h = tmin;
          2: h = dmax;
          3: h = dmax + 1;
          4: h = dmin - 1;
          5: h = dmin;
          6: h = stk;
          default: h = stk + 1;
        endcase
      end
      8: h = $urandom_range(0, tmin);
      default: h = $urandom_range(0, 1) ? stk + 1 + $urandom_range(0, 1000)
                                        : $urandom_range(0, 70000);
    endcase
    return h;
  endfunction

  // Pick a silence between symbols: mostly inside the timeout, some on or past it.
  function automatic logic [31:0] pick_gap();
    int unsigned g;
    logic [31:0] s;
    g = sb.cfg.gap_timeout_ms;
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: s = (g == 0) ? 0 : $urandom_range(0, g - 1);
      5: s = (g == 0) ? 0 : g - 1;
      6: s = g;
      default: s = g + $urandom_range(1, 100);
    endcase
    return s;
  endfunction

  // One keyed word: press and release pairs with random timing, a closing
  // silence, a few samples in the complete phase and usually a clear.
  task automatic send_word();
    int          n;
    logic [31:0] h;
    logic [31:0] g;
    n = $urandom_range(1, 18);
    for (int k = 0; k < n; k++) begin
      emit(FUNC_SAMPLE, 1'b1, now_ms);
      h = pick_hold();
      if ($urandom_range(0, 3) == 0) emit(FUNC_SAMPLE, 1'b1, now_ms + (h >> $urandom_range(1, 4)));
      now_ms += h;
      emit(FUNC_SAMPLE, 1'b0, now_ms);
      if (k < n - 1) begin
        g = pick_gap();
        if ($urandom_range(0, 2) == 0) emit(FUNC_SAMPLE, 1'b0, now_ms + (g >> 1));
        now_ms += g;
      end
    end
    now_ms = now_ms + sb.cfg.gap_timeout_ms + $urandom_range(0, 50);
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    if ($urandom_range(0, 1) == 0) begin
      now_ms += 40;
      emit(FUNC_SAMPLE, 1'b1, now_ms);
      now_ms += 300;
      emit(FUNC_SAMPLE, 1'b0, now_ms);
    end
    if ($urandom_range(0, 4) != 0) emit(FUNC_CLEAR, $urandom_range(0, 1), $urandom);
    now_ms = now_ms + 100 + $urandom_range(0, 1000);
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: any level, any timestamp, an occasional clear
        emit(($urandom_range(0, 9) == 0) ? FUNC_CLEAR : FUNC_SAMPLE,
             $urandom_range(0, 1), $urandom);
      end else begin
        send_word();
      end
    end
  endtask

  // Walk the reset timing through each rule once, across the timestamp wrap.
  task automatic directed_walk();
    emit(FUNC_CLEAR, 1'b1, 32'hFFFF_FFFF);
    emit(FUNC_SAMPLE, 1'b0, 32'h0000_0000);
    now_ms = 32'hFFFF_FF80;
    // too short a tap: no symbol, still goes to gap
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    now_ms += 29;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    // dot exactly at the touch minimum, then exactly at the dot maximum
    now_ms += 100;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    now_ms += 30;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    now_ms += 50;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    now_ms += 200;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    // between the windows: dropped
    now_ms += 50;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    now_ms += 250;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    // dash exactly at the dash minimum
    now_ms += 50;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    now_ms += 300;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    // one short of the timeout, then a press past it: the press wins
    emit(FUNC_SAMPLE, 1'b0, now_ms + 999);
    now_ms += 2000;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    // hold equal to the stuck limit is still a dash
    now_ms += 5000;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    // timeout reached: complete, and presses there change nothing
    now_ms += 1000;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    now_ms += 10;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    now_ms += 100;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    // clear with the key down, then a held key reads as a new press
    emit(FUNC_CLEAR, 1'b1, now_ms);
    now_ms += 10;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    // hold past the stuck limit, then release clears everything
    now_ms += 5001;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    now_ms += 10;
    emit(FUNC_SAMPLE, 1'b1, now_ms);
    now_ms += 10;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
    now_ms += 10;
    emit(FUNC_SAMPLE, 1'b0, now_ms);
  endtask

  initial begin
    cfg_t c;
    sb = new(DEFAULT_SYMBOL_CAPACITY);
    in_valid = 1'b0;
    in_item = '0;
    cfg_wen = 1'b0;
    cfg_index = REG_TOUCH_MIN;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset timing, no idling
    directed_walk();
    wait_idle();

    // restore the reset values explicitly and run random words
    c.touch_min_ms   = RST_TOUCH_MIN;
    c.dot_max_ms     = RST_DOT_MAX;
    c.dash_min_ms    = RST_DASH_MIN;
    c.gap_timeout_ms = RST_GAP_TIMEOUT;
    c.stuck_limit_ms = RST_STUCK_LIMIT;
    set_config(c);
    run_random(300);
    wait_idle();

    // every threshold at zero: a zero hold is a dash, any longer hold is stuck, any silence completes
    c = '0;
    set_config(c);
    set_idling(50, 0);
    run_random(250);
    wait_idle();

    // every threshold at its maximum
    c = '1;
    set_config(c);
    set_idling(0, 50);
    run_random(250);
    wait_idle();

    // long receiver hold-off while items keep coming
    random_config();
    set_idling(35, 35);
    holdoff_req <= holdoff_req + 1;
    run_random(250);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      random_config();
      case (p)
        0: set_idling(0, 0);
        1: set_idling(50, 0);
        2: set_idling(0, 50);
        default: set_idling(35, 35);
      endcase
      run_random(250);
      wait_idle();
    end

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      sb.errors++;
      $error("%0d expected results never arrived", sb.expected_results.size());
    end

    $display("Summary: %0d key items sent, %0d results checked, %0d register settings",
             items_sent, sb.checked, settings_used);
    $display("Summary: %0d results in complete, %0d in stuck, %0d with the store full",
             sb.n_complete, sb.n_stuck, sb.n_full);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Give up well past the slowest legal run.
  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
